/* hw/rtl/yuv420_block_to_rgb_assert.svh */
// Assertion macros for the 4:2:0 block to RGB converter.
`ifndef YUV420_BLOCK_TO_RGB_ASSERT_SVH
`define YUV420_BLOCK_TO_RGB_ASSERT_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define Y2R_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("y2r: next-cycle check failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define Y2R_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("y2r: same-cycle check failed");

`endif

/* hw/rtl/y2r_pkg.sv */
// Types and constants of the 4:2:0 block to RGB converter.
package y2r_pkg;

	localparam int unsigned TERM_W = 10;
	localparam int unsigned SUM_W  = 12;
	localparam int unsigned PROD_W = 20;

	localparam logic signed [10:0] COEF_Y  = 11'sd298;
	localparam logic signed [10:0] COEF_RV = 11'sd409;
	localparam logic signed [10:0] COEF_GV = 11'sd208;
	localparam logic signed [10:0] COEF_GU = 11'sd100;
	localparam logic signed [10:0] COEF_BU = 11'sd516;
	localparam logic signed [9:0]  LUMA_OFS   = 10'sd16;
	localparam logic signed [9:0]  CHROMA_OFS = 10'sd128;
	localparam logic signed [PROD_W-1:0] ROUND = 20'sd128;

	typedef logic signed [TERM_W-1:0] term_t;

	typedef struct packed {
		logic [7:0] luma_top_left;
		logic [7:0] luma_top_right;
		logic [7:0] luma_bottom_left;
		logic [7:0] luma_bottom_right;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} yuv_t;

	typedef struct packed {
		logic [7:0] red_top_left;
		logic [7:0] green_top_left;
		logic [7:0] blue_top_left;
		logic [7:0] red_top_right;
		logic [7:0] green_top_right;
		logic [7:0] blue_top_right;
		logic [7:0] red_bottom_left;
		logic [7:0] green_bottom_left;
		logic [7:0] blue_bottom_left;
		logic [7:0] red_bottom_right;
		logic [7:0] green_bottom_right;
		logic [7:0] blue_bottom_right;
	} rgb_t;

	typedef struct packed {
		term_t rv;
		term_t gv;
		term_t gu;
		term_t bu;
	} chroma_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic valid_s1;
	} ctl_t;

endpackage

/* hw/rtl/y2r_chroma.sv */
// Shared chroma terms of one block, registered into the first stage.
module y2r_chroma (
	input  logic             clk,
	input  y2r_pkg::ctl_t    ctl,
	input  logic [7:0]       chroma_blue,
	input  logic [7:0]       chroma_red,
	output y2r_pkg::chroma_t terms_s1
);

	logic signed [9:0]                   u;
	logic signed [9:0]                   v;
	logic signed [y2r_pkg::PROD_W-1:0]   rv_p;
	logic signed [y2r_pkg::PROD_W-1:0]   gv_p;
	logic signed [y2r_pkg::PROD_W-1:0]   gu_p;
	logic signed [y2r_pkg::PROD_W-1:0]   bu_p;
	y2r_pkg::chroma_t                    terms;

	assign u = $signed({2'b00, chroma_blue}) - y2r_pkg::CHROMA_OFS;
	assign v = $signed({2'b00, chroma_red}) - y2r_pkg::CHROMA_OFS;

	assign rv_p = 20'(v) * 20'(y2r_pkg::COEF_RV) + y2r_pkg::ROUND;
	assign gv_p = 20'(v) * 20'(y2r_pkg::COEF_GV) + y2r_pkg::ROUND;
	assign gu_p = 20'(u) * 20'(y2r_pkg::COEF_GU) + y2r_pkg::ROUND;
	assign bu_p = 20'(u) * 20'(y2r_pkg::COEF_BU) + y2r_pkg::ROUND;

	always_comb begin
		terms.rv = y2r_pkg::term_t'(rv_p >>> 8);
		terms.gv = y2r_pkg::term_t'(gv_p >>> 8);
		terms.gu = y2r_pkg::term_t'(gu_p >>> 8);
		terms.bu = y2r_pkg::term_t'(bu_p >>> 8);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			terms_s1 <= terms;
		end
	end

endmodule

/* hw/rtl/y2r_lane.sv */
// One pixel lane: scaled luma, channel sums and clamping.
module y2r_lane (
	input  logic             clk,
	input  y2r_pkg::ctl_t    ctl,
	input  logic [7:0]       luma,
	input  y2r_pkg::chroma_t terms_s1,
	output y2r_pkg::pix_t    pix_s2
);

	logic signed [9:0]                 yoff;
	logic signed [y2r_pkg::PROD_W-1:0] y_p;
	y2r_pkg::term_t                    yt_s1;
	logic signed [y2r_pkg::SUM_W-1:0]  r_sum;
	logic signed [y2r_pkg::SUM_W-1:0]  g_sum;
	logic signed [y2r_pkg::SUM_W-1:0]  b_sum;
	y2r_pkg::pix_t                     pix;

	function automatic logic [7:0] clamp(input logic signed [y2r_pkg::SUM_W-1:0] s);
		logic [7:0] r;
		if (s < 0) begin
			r = 8'd0;
		end else if (s > 12'sd255) begin
			r = 8'hFF;
		end else begin
			r = s[7:0];
		end
		return r;
	endfunction

	assign yoff = $signed({2'b00, luma}) - y2r_pkg::LUMA_OFS;
	assign y_p  = 20'(yoff) * 20'(y2r_pkg::COEF_Y);

	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			yt_s1 <= y2r_pkg::term_t'(y_p >>> 8);
		end
	end

	assign r_sum = 12'(yt_s1) + 12'(terms_s1.rv);
	assign g_sum = 12'(yt_s1) - 12'(terms_s1.gv) - 12'(terms_s1.gu);
	assign b_sum = 12'(yt_s1) + 12'(terms_s1.bu);

	always_comb begin
		pix.red   = clamp(r_sum);
		pix.green = clamp(g_sum);
		pix.blue  = clamp(b_sum);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			pix_s2 <= pix;
		end
	end

endmodule

/* hw/rtl/y2r_merge.sv */
// Pipeline flow control and packing of the four lanes into one result.
module y2r_merge (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     yuv_valid,
	input  logic                     rgb_stall,
	input  y2r_pkg::pix_t [3:0]      pix_s2,
	output y2r_pkg::ctl_t            ctl,
	output logic                     yuv_stall,
	output logic                     rgb_valid,
	output y2r_pkg::rgb_t            rgb
);

	logic valid_s1;
	logic valid_s2;
	logic adv_s1;
	logic adv_s2;

	assign adv_s2 = !valid_s2 || !rgb_stall;
	assign adv_s1 = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= yuv_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_comb begin
		ctl.adv_s1   = adv_s1;
		ctl.adv_s2   = adv_s2;
		ctl.valid_s1 = valid_s1;
	end

	assign yuv_stall = !adv_s1;
	assign rgb_valid = valid_s2;

	always_comb begin
		rgb.red_top_left       = pix_s2[0].red;
		rgb.green_top_left     = pix_s2[0].green;
		rgb.blue_top_left      = pix_s2[0].blue;
		rgb.red_top_right      = pix_s2[1].red;
		rgb.green_top_right    = pix_s2[1].green;
		rgb.blue_top_right     = pix_s2[1].blue;
		rgb.red_bottom_left    = pix_s2[2].red;
		rgb.green_bottom_left  = pix_s2[2].green;
		rgb.blue_bottom_left   = pix_s2[2].blue;
		rgb.red_bottom_right   = pix_s2[3].red;
		rgb.green_bottom_right = pix_s2[3].green;
		rgb.blue_bottom_right  = pix_s2[3].blue;
	end

endmodule

/* hw/rtl/yuv420_block_to_rgb.sv */
// Converts one 2x2 block of 4:2:0 video (four luma, shared U and V) into four
// RGB888 pixels with BT.601 integer coefficients and clamping. A block is
// taken every cycle while yuv_stall is low; the first stage forms the chroma
// terms and the four scaled lumas with constant multiplies, the second forms
// and clamps the channel sums in four side-by-side lanes. The result register
// holds a valid result while rgb_stall is high, and yuv_stall is high in the
// same cycle once both stages hold a block and rgb_stall is high.
`include "yuv420_block_to_rgb_assert.svh"

module yuv420_block_to_rgb (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          yuv_valid,
	output logic          yuv_stall,
	input  y2r_pkg::yuv_t yuv,
	output logic          rgb_valid,
	input  logic          rgb_stall,
	output y2r_pkg::rgb_t rgb
);

	y2r_pkg::ctl_t            ctl;
	y2r_pkg::chroma_t         terms_s1;
	y2r_pkg::pix_t [3:0]      pix_s2;
	logic [3:0][7:0]          luma;

	assign luma[0] = yuv.luma_top_left;
	assign luma[1] = yuv.luma_top_right;
	assign luma[2] = yuv.luma_bottom_left;
	assign luma[3] = yuv.luma_bottom_right;

	y2r_chroma u_chroma (
		.clk         (clk),
		.ctl         (ctl),
		.chroma_blue (yuv.chroma_blue),
		.chroma_red  (yuv.chroma_red),
		.terms_s1    (terms_s1)
	);

	for (genvar i = 0; i < 4; i++) begin : g_lane
		y2r_lane u_lane (
			.clk      (clk),
			.ctl      (ctl),
			.luma     (luma[i]),
			.terms_s1 (terms_s1),
			.pix_s2   (pix_s2[i])
		);
	end

	y2r_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.yuv_valid (yuv_valid),
		.rgb_stall (rgb_stall),
		.pix_s2    (pix_s2),
		.ctl       (ctl),
		.yuv_stall (yuv_stall),
		.rgb_valid (rgb_valid),
		.rgb       (rgb)
	);

	`Y2R_ASSERT_SAME(a_ready_when_drained, (!rgb_valid || !rgb_stall), !yuv_stall)
	`Y2R_ASSERT_NEXT(a_transfer_fills_s1, (yuv_valid && !yuv_stall), ctl.valid_s1)
	`Y2R_ASSERT_NEXT(a_s1_reaches_output, (ctl.valid_s1 && ctl.adv_s2), rgb_valid)

endmodule

/* tb/yuv420_block_to_rgb_tb.sv */
// Self-checking testbench for the 4:2:0 block to RGB888 converter.
module yuv420_block_to_rgb_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT    = 200000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned NUM_DIRECTED   = 18;

	typedef struct packed {
		y2r_pkg::yuv_t blk;
		logic          typed;
		y2r_pkg::rgb_t want;
	} vector_t;

	localparam vector_t DIRECTED_BLOCKS [NUM_DIRECTED] = '{
		{8'd16,  8'd16,  8'd16,  8'd16,  8'd128, 8'd128, 1'b1, {12{8'h00}}},
		{8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128, 1'b1, {12{8'hFE}}},
		{8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128, 1'b1, {12{8'hFF}}},
		{8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128, 1'b1, {12{8'h00}}},
		{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
			{4{8'h00, 8'd135, 8'h00}}},
		{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1,
			{4{8'hFF, 8'd125, 8'hFF}}},
		{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 96'h0},
		{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   1'b0, 96'h0},
		{8'h00,  8'hFF,  8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0, 96'h0},
		{8'hAA,  8'h55,  8'hFF,  8'h00,  8'hAA,  8'h55,  1'b0, 96'h0},
		{8'h01,  8'h02,  8'h04,  8'h08,  8'h10,  8'h20,  1'b0, 96'h0},
		{8'h80,  8'h40,  8'h20,  8'h10,  8'h01,  8'h80,  1'b0, 96'h0},
		{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 1'b0, 96'h0},
		{8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd128, 1'b0, 96'h0},
		{8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd128, 1'b0, 96'h0},
		{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   1'b0, 96'h0},
		{8'd16,  8'd235, 8'd100, 8'd200, 8'd240, 8'd16,  1'b0, 96'h0},
		{8'd81,  8'd145, 8'd41,  8'd210, 8'd16,  8'd240, 1'b0, 96'h0}
	};

	localparam string CHANNEL_NAMES [12] = '{
		"red_top_left", "green_top_left", "blue_top_left",
		"red_top_right", "green_top_right", "blue_top_right",
		"red_bottom_left", "green_bottom_left", "blue_bottom_left",
		"red_bottom_right", "green_bottom_right", "blue_bottom_right"
	};

	logic          clk;
	logic          arst_n;
	logic          yuv_valid;
	logic          yuv_stall;
	y2r_pkg::yuv_t yuv;
	logic          rgb_valid;
	logic          rgb_stall;
	y2r_pkg::rgb_t rgb;

	y2r_pkg::rgb_t pending_rgb [$];
	int unsigned   mismatch_count;
	int unsigned   cycle_count;
	int unsigned   sender_idle_pct;
	int unsigned   receiver_stall_pct;
	bit            hold_off_request;

	yuv420_block_to_rgb DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.yuv_valid (yuv_valid),
		.yuv_stall (yuv_stall),
		.yuv       (yuv),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

	function automatic logic [7:0] saturate_channel(int signed sum);
		if (sum < 0)
			return 8'h00;
		if (sum > 255)
			return 8'hFF;
		return sum[7:0];
	endfunction

	function automatic y2r_pkg::rgb_t convert_block(y2r_pkg::yuv_t blk);
		int signed   u;
		int signed   v;
		int signed   red_term;
		int signed   green_v_term;
		int signed   green_u_term;
		int signed   blue_term;
		int signed   luma_term;
		logic [7:0]  luma [4];
		logic [95:0] pixels;
		u            = int'(blk.chroma_blue) - 128;
		v            = int'(blk.chroma_red) - 128;
		red_term     = (409 * v + 128) >>> 8;
		green_v_term = (208 * v + 128) >>> 8;
		green_u_term = (100 * u + 128) >>> 8;
		blue_term    = (516 * u + 128) >>> 8;
		luma = '{blk.luma_top_left, blk.luma_top_right,
			blk.luma_bottom_left, blk.luma_bottom_right};
		for (int p = 0; p < 4; p++) begin
			luma_term = (298 * (int'(luma[p]) - 16)) >>> 8;
			pixels[95 - 24 * p -: 24] = {saturate_channel(luma_term + red_term),
				saturate_channel(luma_term - green_v_term - green_u_term),
				saturate_channel(luma_term + blue_term)};
		end
		return y2r_pkg::rgb_t'(pixels);
	endfunction

	function automatic logic [7:0] random_sample();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'(($urandom_range(1)) ? 16 : 235);
			3: return 8'($urandom_range(120, 136));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic y2r_pkg::yuv_t random_block();
		y2r_pkg::yuv_t blk;
		blk.luma_top_left     = random_sample();
		blk.luma_top_right    = random_sample();
		blk.luma_bottom_left  = random_sample();
		blk.luma_bottom_right = random_sample();
		blk.chroma_blue       = random_sample();
		blk.chroma_red        = random_sample();
		return blk;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic offer_block(input y2r_pkg::yuv_t blk, input logic typed,
		input y2r_pkg::rgb_t want);
		while ($urandom_range(99) < sender_idle_pct) begin
			yuv_valid <= 1'b0;
			yuv       <= random_block();
			@(negedge clk);
		end
		yuv_valid <= 1'b1;
		yuv       <= blk;
		@(posedge clk);
		while (yuv_stall)
			@(posedge clk);
		pending_rgb.push_back(typed ? want : convert_block(blk));
		@(negedge clk);
	endtask

	task automatic offer_random_blocks(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			offer_block(random_block(), 1'b0, '0);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** yuv420_block_to_rgb: FAILED **");
			$finish;
		end
	end

	initial begin
		rgb_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				rgb_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			rgb_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		y2r_pkg::rgb_t want;
		if (arst_n && rgb_valid && !rgb_stall) begin
			if (pending_rgb.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected transfer out, actual %h", $time, rgb);
			end else begin
				want = pending_rgb.pop_front();
				for (int c = 0; c < 12; c++) begin
					if (rgb[95 - 8 * c -: 8] !== want[95 - 8 * c -: 8]) begin
						mismatch_count++;
						$display("%0t: %s expected %h actual %h", $time, CHANNEL_NAMES[c],
							want[95 - 8 * c -: 8], rgb[95 - 8 * c -: 8]);
					end
				end
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		yuv_valid          = 1'b0;
		yuv                = '0;
		mismatch_count     = 0;
		cycle_count        = 0;
		hold_off_request   = 1'b0;
		sender_idle_pct    = 29;
		receiver_stall_pct = 62;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++)
			offer_block(DIRECTED_BLOCKS[i].blk, DIRECTED_BLOCKS[i].typed,
				DIRECTED_BLOCKS[i].want);
		offer_random_blocks(600);

		sender_idle_pct    = 62;
		receiver_stall_pct = 29;
		offer_random_blocks(600);

		// Fill the pipeline behind a long hold-off and keep offering.
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		hold_off_request   = 1'b1;
		offer_random_blocks(40);

		offer_random_blocks(600);
		yuv_valid <= 1'b0;

		while (pending_rgb.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_rgb.size() == 0)
			$display("** yuv420_block_to_rgb: PASSED **");
		else
			$display("** yuv420_block_to_rgb: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/y2r_pkg.sv
hw/rtl/y2r_chroma.sv
hw/rtl/y2r_lane.sv
hw/rtl/y2r_merge.sv
hw/rtl/yuv420_block_to_rgb.sv
tb/yuv420_block_to_rgb_tb.sv
